/* rtl/mmrp_pkg.sv */
// shared types, constants and the byte-wide crc-16 update for the meter
// response parser; no dependencies
package mmrp_pkg;

  localparam int unsigned FRAME_LIMIT   = 256;
  localparam int unsigned POS_W         = $clog2(FRAME_LIMIT + 1);
  localparam int unsigned MIN_FRAME     = 29;
  localparam int unsigned WORD_COUNT    = 6;
  localparam int unsigned FIRST_CAPTURE = 3;
  localparam int unsigned LAST_CAPTURE  = 26;

  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  ADDR_RESET = 8'h01;

  typedef logic [31:0] word_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ADDRESS = 2'd1,
    ST_CRC     = 2'd2,
    ST_SHORT   = 2'd3
  } status_e;

  // end-of-frame result handed from the frame tracker to the result stage
  typedef struct packed {
    logic                       load;
    status_e                    status;
    word_t [WORD_COUNT-1:0]     words;
  } verdict_t;

  // reflected crc-16, one byte: eight shift steps unrolled
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/mmrp_crc.sv */
// running modbus crc-16 register, one byte per processed beat
// depends on mmrp_pkg
module mmrp_crc import mmrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       last_i,
  input  logic [7:0] byte_i,
  output logic       residue_zero_o
);

  logic [15:0] crc_q, crc_d, crc_next;

  assign crc_next       = crc_feed(crc_q, byte_i);
  assign residue_zero_o = (crc_next == 16'h0000);

  always_comb begin
    crc_d = crc_q;
    if (en_i) begin
      crc_d = last_i ? CRC_SEED : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_SEED;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

/* rtl/mmrp_frame.sv */
// frame tracker: byte position, address match and word capture, plus the
// end-of-frame verdict; depends on mmrp_pkg
module mmrp_frame import mmrp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       last_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] dev_addr_i,
  input  logic       residue_zero_i,
  output verdict_t   verdict_o
);

  pos_t                   pos_q, pos_d, pos_next, pos_off;
  logic                   addr_q, addr_d, addr_next;
  word_t [WORD_COUNT-1:0] words_q, words_d, words_next;
  logic                   capture;
  logic [2:0]             widx;

  assign addr_next = (pos_q == '0) ? (byte_i == dev_addr_i) : addr_q;
  assign pos_next  = (pos_q < POS_W'(FRAME_LIMIT)) ? pos_q + POS_W'(1) : pos_q;
  assign capture   = (pos_q >= POS_W'(FIRST_CAPTURE)) && (pos_q <= POS_W'(LAST_CAPTURE));
  assign pos_off   = pos_q - POS_W'(FIRST_CAPTURE);
  assign widx      = pos_off[4:2];

  always_comb begin
    for (int w = 0; w < WORD_COUNT; w++) begin
      if (capture && widx == 3'(w)) begin
        words_next[w] = {words_q[w][23:0], byte_i};
      end else begin
        words_next[w] = words_q[w];
      end
    end
  end

  // priority: address, then short frame, then crc
  always_comb begin
    verdict_o.load  = en_i && last_i;
    verdict_o.words = words_next;
    if (!addr_next) begin
      verdict_o.status = ST_ADDRESS;
    end else if (pos_next < POS_W'(MIN_FRAME)) begin
      verdict_o.status = ST_SHORT;
    end else if (!residue_zero_i) begin
      verdict_o.status = ST_CRC;
    end else begin
      verdict_o.status = ST_OK;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    addr_d  = addr_q;
    words_d = words_q;
    if (en_i) begin
      if (last_i) begin
        pos_d   = '0;
        addr_d  = 1'b0;
        words_d = '0;
      end else begin
        pos_d   = pos_next;
        addr_d  = addr_next;
        words_d = words_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      addr_q  <= 1'b0;
      words_q <= '0;
    end else begin
      pos_q   <= pos_d;
      addr_q  <= addr_d;
      words_q <= words_d;
    end
  end

endmodule

/* rtl/mmrp_result.sv */
// result register: status, the held good words and the output valid
// depends on mmrp_pkg
module mmrp_result import mmrp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  verdict_t               verdict_i,
  input  logic                   out_stall_i,
  output logic                   can_load_o,
  output logic                   out_valid_o,
  output status_e                status_o,
  output word_t [WORD_COUNT-1:0] good_o
);

  logic                   valid_q, valid_d;
  status_e                status_q, status_d;
  word_t [WORD_COUNT-1:0] good_q, good_d;

  assign can_load_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign status_o    = status_q;
  // good words only move on a load, so they hold while a beat waits
  assign good_o      = good_q;

  always_comb begin
    valid_d  = valid_q && out_stall_i;
    status_d = status_q;
    good_d   = good_q;
    if (verdict_i.load) begin
      valid_d  = 1'b1;
      status_d = verdict_i.status;
      if (verdict_i.status == ST_OK) begin
        good_d = verdict_i.words;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      good_q  <= '0;
    end else begin
      valid_q <= valid_d;
      good_q  <= good_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_i.load |-> can_load_o)
    else $error("result loaded while a beat is waiting");

  a_hold_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |=> $stable(good_q))
    else $error("good words changed under a waiting beat");

  a_good_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_i.load && verdict_i.status != ST_OK) |=> $stable(good_q))
    else $error("good words changed on a failed frame");

endmodule

/* rtl/modbus_meter_response_parser.sv */
// modbus rtu meter response parser: input register, crc and frame tracking,
// result register; depends on mmrp_pkg, mmrp_crc, mmrp_frame, mmrp_result
// path: a last byte passes the input register, then the result register
// throughput: one byte per cycle; a last byte waits in the input register
// only while an earlier result is still stalled at the output
// reset: async active low, clears frame state, good words, address to 1
module modbus_meter_response_parser import mmrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        device_address_we_i,
  input  logic [7:0]  device_address_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] voltage_value_o,
  output logic [31:0] current_value_o,
  output logic [31:0] power_value_o,
  output logic [31:0] energy_value_o,
  output logic [31:0] power_factor_value_o,
  output logic [31:0] carbon_value_o
);

  logic [7:0]             addr_q;
  logic                   s1_valid_q, s1_valid_d;
  logic [7:0]             s1_byte_q;
  logic                   s1_last_q;
  logic                   in_accept, proc, can_load, residue_zero;
  verdict_t               verdict;
  status_e                status;
  word_t [WORD_COUNT-1:0] good;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= ADDR_RESET;
    end else if (device_address_we_i) begin
      addr_q <= device_address_i;
    end
  end

  // plain bytes always move on; a last byte needs room in the result register
  assign proc       = s1_valid_q && (!s1_last_q || can_load);
  assign in_stall_o = s1_valid_q && !proc;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !proc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  mmrp_crc u_crc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (proc),
    .last_i         (s1_last_q),
    .byte_i         (s1_byte_q),
    .residue_zero_o (residue_zero)
  );

  mmrp_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (proc),
    .last_i         (s1_last_q),
    .byte_i         (s1_byte_q),
    .dev_addr_i     (addr_q),
    .residue_zero_i (residue_zero),
    .verdict_o      (verdict)
  );

  mmrp_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .verdict_i   (verdict),
    .out_stall_i (out_stall_i),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .status_o    (status),
    .good_o      (good)
  );

  assign status_o             = status;
  assign voltage_value_o      = good[0];
  assign current_value_o      = good[1];
  assign power_value_o        = good[2];
  assign energy_value_o       = good[3];
  assign power_factor_value_o = good[4];
  assign carbon_value_o       = good[5];

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_last_q && out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q)))
    else $error("input register lost a stalled byte");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && s1_last_q) |=> out_valid_o)
    else $error("last byte processed without a result");

endmodule

/* sim/tb_modbus_meter_response_parser.sv */
// testbench for modbus_meter_response_parser: sends modbus reply frames byte by byte
// and checks each end-of-frame reading against a scoreboard that tracks crc and words
// depends on mmrp_pkg and the parser rtl
module tb_modbus_meter_response_parser;
  import mmrp_pkg::*;

  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned PHASE_BYTES     = 90;
  localparam int unsigned PHASE_FRAMES    = 3;
  localparam int unsigned PHASE_COUNT     = 5;

  typedef struct packed {
    status_e                status;
    word_t [WORD_COUNT-1:0] words;
  } meter_reading_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_e;

  class meter_scoreboard;
    logic [7:0]     slave_address;
    logic [15:0]    crc;
    int unsigned    position;
    bit             addr_ok;
    word_t          frame_w [WORD_COUNT];
    word_t          good_w [WORD_COUNT];
    string          field_names [WORD_COUNT];
    meter_reading_t readings_due [$];
    int unsigned    mismatches;

    function new();
      slave_address = ADDR_RESET;
      mismatches    = 0;
      foreach (good_w[i]) good_w[i] = '0;
      field_names = '{"voltage_value", "current_value", "power_value", "energy_value",
                      "power_factor_value", "carbon_value"};
      clear_frame();
    endfunction

    static function logic [15:0] crc16_byte(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      repeat (8) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void clear_frame();
      crc      = CRC_SEED;
      position = 0;
      addr_ok  = 1'b0;
      foreach (frame_w[i]) frame_w[i] = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic is_last);
      meter_reading_t r;
      int unsigned    w;
      if (position == 0) addr_ok = (b == slave_address);
      crc = crc16_byte(crc, b);
      if (position >= FIRST_CAPTURE && position <= LAST_CAPTURE) begin
        w = (position - FIRST_CAPTURE) >> 2;
        frame_w[w] = {frame_w[w][23:0], b};
      end
      if (position < FRAME_LIMIT) position++;
      if (!is_last) return;
      // address beats short frame, short frame beats crc
      if (!addr_ok) r.status = ST_ADDRESS;
      else if (position < MIN_FRAME) r.status = ST_SHORT;
      else if (crc != 16'h0000) r.status = ST_CRC;
      else r.status = ST_OK;
      if (r.status == ST_OK) good_w = frame_w;
      foreach (good_w[i]) r.words[i] = good_w[i];
      readings_due.push_back(r);
      clear_frame();
    endfunction

    function void check_reading(logic [1:0] st, word_t got [WORD_COUNT]);
      meter_reading_t want;
      if (readings_due.size() == 0) begin
        $error("result with no frame pending: status %0d", st);
        mismatches++;
        return;
      end
      want = readings_due.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        mismatches++;
      end
      foreach (got[i]) begin
        if (got[i] !== want.words[i]) begin
          $error("%s: expected %h, got %h", field_names[i], want.words[i], got[i]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni              = 1'b0;
  logic        device_address_we_i = 1'b0;
  logic [7:0]  device_address_i    = 8'h00;
  logic        in_valid_i          = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i         = 8'h00;
  logic        last_byte_i         = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i         = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] voltage_value_o;
  logic [31:0] current_value_o;
  logic [31:0] power_value_o;
  logic [31:0] energy_value_o;
  logic [31:0] power_factor_value_o;
  logic [31:0] carbon_value_o;

  meter_scoreboard sb;
  stall_mode_e     stall_mode  = STALL_NONE;
  bit              sender_gaps = 1'b0;
  int unsigned     burst_left  = 0;
  int unsigned     stall_run   = 0;
  int unsigned     quiet_cycles = 0;
  logic [7:0]      frame_q [$];
  word_t           seen_words [WORD_COUNT];

  modbus_meter_response_parser u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .device_address_we_i (device_address_we_i),
    .device_address_i    (device_address_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .last_byte_i         (last_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .voltage_value_o     (voltage_value_o),
    .current_value_o     (current_value_o),
    .power_value_o       (power_value_o),
    .energy_value_o      (energy_value_o),
    .power_factor_value_o(power_factor_value_o),
    .carbon_value_o      (carbon_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // input and result beats, sampled on the edge that accepts them
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_byte(data_byte_i, last_byte_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_words[0] = voltage_value_o;
      seen_words[1] = current_value_o;
      seen_words[2] = power_value_o;
      seen_words[3] = energy_value_o;
      seen_words[4] = power_factor_value_o;
      seen_words[5] = carbon_value_o;
      sb.check_reading(status_o, seen_words);
    end
  end

  always @(posedge clk_i) begin
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 9) < 3);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
      default: begin
        if (stall_run == 0) begin
          out_stall_i <= ~out_stall_i;
          stall_run   <= $urandom_range(1, 16);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'hFF;
      1:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void start_reply(input logic [7:0] addr, input int unsigned payload_len);
    frame_q.delete();
    frame_q.push_back(addr);
    frame_q.push_back(FN_READ_HOLDING);
    frame_q.push_back(payload_len[7:0]);
    repeat (payload_len) frame_q.push_back(payload_byte());
  endfunction

  // trailing crc goes out low byte first
  function automatic void seal_frame();
    logic [15:0] c;
    c = CRC_SEED;
    foreach (frame_q[i]) c = meter_scoreboard::crc16_byte(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endfunction

  function automatic void build_random_frame(input logic [7:0] addr);
    int unsigned pick;
    int unsigned len;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      start_reply(addr, 24);
      seal_frame();
    end else if (pick < 60) begin
      start_reply(addr, 24 + $urandom_range(1, 12));
      seal_frame();
    end else if (pick < 68) begin
      start_reply(addr ^ 8'($urandom_range(1, 255)), 24);
      seal_frame();
    end else if (pick < 80) begin
      start_reply(addr, 24);
      seal_frame();
      idx = $urandom_range(1, frame_q.size() - 1);
      frame_q[idx][$urandom_range(0, 7)] ^= 1'b1;
    end else if (pick < 90) begin
      // short frame, sometimes with a valid trailing crc
      len = $urandom_range(1, MIN_FRAME - 1);
      frame_q.delete();
      frame_q.push_back(addr);
      if (len >= 3 && $urandom_range(0, 1)) begin
        repeat (len - 3) frame_q.push_back(payload_byte());
        seal_frame();
      end else begin
        repeat (len - 1) frame_q.push_back(payload_byte());
      end
    end else if (pick < 98) begin
      len = $urandom_range(1, 40);
      frame_q.delete();
      frame_q.push_back($urandom_range(0, 1) ? addr : 8'($urandom));
      repeat (len - 1) frame_q.push_back(8'($urandom));
    end else begin
      start_reply(addr, $urandom_range(FRAME_LIMIT - 4, FRAME_LIMIT + 30));
      seal_frame();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = 0;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_range(input int unsigned from_idx, input int unsigned to_idx);
    for (int unsigned i = from_idx; i < to_idx; i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // bytes without a mark give no result, so give the pipeline time to empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.readings_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] a);
    device_address_we_i <= 1'b1;
    device_address_i    <= a;
    @(posedge clk_i);
    sb.slave_address = a;
    device_address_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0]  phase_addr;
    int unsigned split_at;
    int unsigned phase_bytes;
    int unsigned phase_frames;
    sb       = new();
    split_at = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one-byte frames under the reset address, then a good reply with extreme words
    send_byte(ADDR_RESET, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    frame_q.delete();
    frame_q.push_back(ADDR_RESET);
    frame_q.push_back(FN_READ_HOLDING);
    frame_q.push_back(8'd24);
    for (int i = 0; i < 24; i++) begin
      frame_q.push_back(i < 4 ? 8'hFF : (i < 8 ? 8'h00 : payload_byte()));
    end
    seal_frame();
    send_range(0, frame_q.size());

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       phase_addr = 8'hFF;
        1:       phase_addr = 8'h00;
        4:       phase_addr = ADDR_RESET;
        default: phase_addr = 8'($urandom);
      endcase
      wait_idle();
      write_address(phase_addr);
      stall_mode  = stall_mode_e'(p % 4);
      sender_gaps = (p != 2);
      // finish a frame whose address byte went in before the register changed
      if (split_at != 0) begin
        send_range(split_at, frame_q.size());
        split_at = 0;
      end
      if (p == 0) begin
        start_reply(phase_addr, FRAME_LIMIT + $urandom_range(0, 20));
        seal_frame();
        send_range(0, frame_q.size());
      end
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
        build_random_frame(phase_addr);
        send_range(0, frame_q.size());
        phase_bytes  += frame_q.size();
        phase_frames++;
      end
      if (p == 1) begin
        start_reply(phase_addr, 24);
        seal_frame();
        split_at = $urandom_range(1, 20);
        send_range(0, split_at);
      end
    end

    in_valid_i <= 1'b0;
    while (sb.readings_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mmrp_pkg.sv
rtl/mmrp_crc.sv
rtl/mmrp_frame.sv
rtl/mmrp_result.sv
rtl/modbus_meter_response_parser.sv
sim/tb_modbus_meter_response_parser.sv
